FILE: src/sdspi_pkg.sv
// Shared types and constants for the SD SPI-mode transaction engine.
// No dependencies.
package sdspi_pkg;

    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned BCW = $clog2(BLOCK_BYTES + 1);

    localparam logic [7:0] BYTE_IDLE    = 8'hFF;
    localparam logic [7:0] CMD_PREFIX   = 8'h40;
    localparam logic [7:0] CRC_CMD0     = 8'h95;
    localparam logic [7:0] CRC_CMD8     = 8'h87;
    localparam logic [7:0] TOKEN_SINGLE = 8'hFE;
    localparam logic [7:0] TOKEN_MULTI  = 8'hFC;
    localparam logic [7:0] TOKEN_STOP   = 8'hFD;
    localparam logic [4:0] DRESP_MASKED_OK = 5'h05;
    localparam logic [5:0] CMD_STOP_TRANS = 6'd12;

    localparam logic [2:0] KIND_CMD      = 3'd0;
    localparam logic [2:0] KIND_RD_SINGLE = 3'd1;
    localparam logic [2:0] KIND_RD_MULTI = 3'd2;
    localparam logic [2:0] KIND_WR_MULTI = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_R1_ERR    = 3'd1;
    localparam logic [2:0] ST_RESP_TO   = 3'd2;
    localparam logic [2:0] ST_REJECTED  = 3'd3;
    localparam logic [2:0] ST_BUSY_TO   = 3'd4;

    localparam logic [0:0] OP_START = 1'b0;

    localparam logic [0:0] REG_RESP_LIMIT = 1'b0;
    localparam logic [0:0] REG_BUSY_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_CMD, PH_R1, PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC, PH_STOP,
        PH_STOP_R1, PH_WR_PRE, PH_WR_DATA, PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY,
        PH_WR_FD, PH_WR_FD_SENT, PH_STOP_BUSY
    } phase_t;

    // classified request handed from front to back
    typedef struct packed {
        logic       start;
        logic [2:0] kind;
        logic [5:0] cmd_index;
        logic [31:0] argument;
        logic [7:0] blocks;
        logic [7:0] rx_byte;
        logic [7:0] write_data;
        logic       rx_ff;
        logic       dresp_ok;
    } req_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       chip_select;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       write_taken;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] response;
    } res_t;

    function automatic logic [7:0] frame_byte(input logic [5:0] cmd,
                                              input logic [31:0] arg,
                                              input logic [2:0] n);
        logic [7:0] b;
        unique case (n)
            3'd0: b = CMD_PREFIX | {2'b00, cmd};
            3'd1: b = arg[31:24];
            3'd2: b = arg[23:16];
            3'd3: b = arg[15:8];
            3'd4: b = arg[7:0];
            default: b = (cmd == 6'd0) ? CRC_CMD0 : (cmd == 6'd8) ? CRC_CMD8 : BYTE_IDLE;
        endcase
        return b;
    endfunction

endpackage

FILE: src/sdspi_front.sv
// Front end: accepts requests, normalizes the start fields and flags received bytes.
// Depends on sdspi_pkg.
module sdspi_front import sdspi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [2:0]  s_kind,
    input  logic [5:0]  s_cmd_index,
    input  logic [31:0] s_argument,
    input  logic [7:0]  s_block_count,
    input  logic [7:0]  s_rx_byte,
    input  logic [7:0]  s_write_data,
    output logic        q_valid,
    input  logic        q_ready,
    output req_t        q_req
);
    // two-entry queue
    req_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    req_t r;
    logic [2:0] k;
    logic push, pop;

    always_comb begin
        k = (s_kind > KIND_WR_MULTI) ? KIND_CMD : s_kind;
        r.start = (s_op == OP_START);
        r.kind = k;
        r.cmd_index = s_cmd_index;
        r.argument = s_argument;
        r.blocks = ((k == KIND_RD_MULTI || k == KIND_WR_MULTI) && s_block_count != 8'd0)
                   ? s_block_count : 8'd1;
        r.rx_byte = s_rx_byte;
        r.write_data = s_write_data;
        r.rx_ff = (s_rx_byte == BYTE_IDLE);
        r.dresp_ok = (s_rx_byte[4:0] == DRESP_MASKED_OK);
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req = mem_reg[rp_reg];
    assign push = s_valid && s_ready;
    assign pop = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= r;
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop && cnt_reg == 2'd0 |=> cnt_reg == 2'd1) else $error("count step");
`endif
endmodule

FILE: src/sdspi_back.sv
// Back end: the transaction sequencer and the output register.
// Depends on sdspi_pkg.
module sdspi_back import sdspi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  req_t        q_req,
    input  logic [7:0]  resp_limit,
    input  logic [15:0] busy_limit,
    output logic        m_valid,
    input  logic        m_ready,
    output res_t        m_res
);
    phase_t phase_reg, phase_next;
    logic [BCW-1:0] bc_reg, bc_next;
    logic [7:0] bl_reg, bl_next;
    logic [15:0] pc_reg, pc_next;
    logic [5:0] cmd_reg, cmd_next;
    logic [31:0] arg_reg, arg_next;
    logic [2:0] kind_reg, kind_next;
    res_t o;
    res_t res_reg;
    logic mv_reg;
    logic fire;
    logic is_read, is_multi, resp_to, busy_to;

    assign q_ready = !mv_reg || m_ready;
    assign fire = q_valid && q_ready;
    assign m_valid = mv_reg;
    assign m_res = res_reg;

    assign is_read = (kind_reg == KIND_RD_SINGLE || kind_reg == KIND_RD_MULTI);
    assign is_multi = (kind_reg == KIND_RD_MULTI || kind_reg == KIND_WR_MULTI);
    assign resp_to = (pc_reg >= {8'd0, resp_limit});
    assign busy_to = (pc_reg >= busy_limit);

    // next state and counters
    always_comb begin
        phase_next = phase_reg; bc_next = bc_reg; bl_next = bl_reg; pc_next = pc_reg;
        cmd_next = cmd_reg; arg_next = arg_reg; kind_next = kind_reg;
        if (q_req.start) begin
            kind_next = q_req.kind; cmd_next = q_req.cmd_index;
            arg_next = q_req.argument; bl_next = q_req.blocks;
            pc_next = 16'd0; bc_next = BCW'(1); phase_next = PH_CMD;
        end else begin
            unique case (phase_reg)
                PH_CMD, PH_STOP: begin
                    if (bc_reg < BCW'(6)) bc_next = bc_reg + BCW'(1);
                    else begin
                        phase_next = (phase_reg == PH_CMD) ? PH_R1 : PH_STOP_R1;
                        pc_next = 16'd1;
                    end
                end
                PH_R1, PH_STOP_R1: begin
                    priority if (q_req.rx_ff) begin
                        if (resp_to) phase_next = PH_IDLE;
                        else pc_next = pc_reg + 16'd1;
                    end else if (phase_reg == PH_STOP_R1 || kind_reg == KIND_CMD
                                 || q_req.rx_byte != 8'd0) phase_next = PH_IDLE;
                    else if (is_read) phase_next = PH_RD_TOKEN;
                    else begin phase_next = PH_WR_PRE; bc_next = BCW'(1); end
                end
                PH_RD_TOKEN: if (q_req.rx_byte == TOKEN_SINGLE) begin
                    phase_next = PH_RD_DATA; bc_next = '0;
                end
                PH_RD_DATA, PH_WR_DATA: begin
                    if (bc_reg + BCW'(1) >= BCW'(BLOCK_BYTES)) begin
                        phase_next = (phase_reg == PH_RD_DATA) ? PH_RD_CRC : PH_WR_CRC;
                        bc_next = '0;
                    end else bc_next = bc_reg + BCW'(1);
                end
                PH_RD_CRC: begin
                    bc_next = bc_reg + BCW'(1);
                    if (bc_reg != '0) begin
                        if (bl_reg != 8'd0) bl_next = bl_reg - 8'd1;
                        if (!is_multi) phase_next = PH_IDLE;
                        else if (bl_reg > 8'd1) phase_next = PH_RD_TOKEN;
                        else begin phase_next = PH_STOP; bc_next = BCW'(1); end
                    end
                end
                PH_WR_PRE: begin
                    if (bc_reg < BCW'(3)) bc_next = bc_reg + BCW'(1);
                    else begin phase_next = PH_WR_DATA; bc_next = '0; end
                end
                PH_WR_CRC: begin
                    if (bc_reg < BCW'(2)) bc_next = bc_reg + BCW'(1);
                    else begin phase_next = PH_WR_RESP; pc_next = 16'd1; end
                end
                PH_WR_RESP: begin
                    priority if (q_req.rx_ff) begin
                        if (resp_to) phase_next = PH_IDLE;
                        else pc_next = pc_reg + 16'd1;
                    end else if (!q_req.dresp_ok) phase_next = PH_IDLE;
                    else begin
                        if (bl_reg != 8'd0) bl_next = bl_reg - 8'd1;
                        phase_next = PH_WR_BUSY; pc_next = 16'd1;
                    end
                end
                PH_WR_BUSY, PH_STOP_BUSY: begin
                    priority if (q_req.rx_ff) begin
                        if (phase_reg == PH_STOP_BUSY || !is_multi) phase_next = PH_IDLE;
                        else if (bl_reg != 8'd0) begin
                            phase_next = PH_WR_PRE; bc_next = '0;
                        end else phase_next = PH_WR_FD;
                    end else if (busy_to) phase_next = PH_IDLE;
                    else pc_next = pc_reg + 16'd1;
                end
                PH_WR_FD: phase_next = PH_WR_FD_SENT;
                PH_WR_FD_SENT: begin phase_next = PH_STOP_BUSY; pc_next = 16'd1; end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // result byte
    always_comb begin
        o = '0;
        o.tx_byte = BYTE_IDLE;
        o.chip_select = 1'b1;
        if (q_req.start) begin
            o.tx_byte = frame_byte(q_req.cmd_index, q_req.argument, 3'd0);
        end else begin
            unique case (phase_reg)
                PH_IDLE: o.chip_select = 1'b0;
                PH_CMD: if (bc_reg < BCW'(6)) o.tx_byte = frame_byte(cmd_reg, arg_reg, bc_reg[2:0]);
                PH_STOP: if (bc_reg < BCW'(6))
                    o.tx_byte = frame_byte(CMD_STOP_TRANS, 32'd0, bc_reg[2:0]);
                PH_RD_DATA: begin o.read_valid = 1'b1; o.read_byte = q_req.rx_byte; end
                PH_RD_CRC: if (bc_reg != '0 && is_multi && bl_reg <= 8'd1)
                    o.tx_byte = frame_byte(CMD_STOP_TRANS, 32'd0, 3'd0);
                PH_WR_PRE: if (bc_reg >= BCW'(3))
                    o.tx_byte = is_multi ? TOKEN_MULTI : TOKEN_SINGLE;
                PH_WR_DATA: begin o.tx_byte = q_req.write_data; o.write_taken = 1'b1; end
                PH_WR_FD: o.tx_byte = TOKEN_STOP;
                default: ;
            endcase
            if (phase_reg != PH_IDLE && phase_next == PH_IDLE) begin
                o.chip_select = 1'b0; o.tx_byte = BYTE_IDLE; o.done_res = 1'b1;
                unique case (phase_reg)
                    PH_R1, PH_STOP_R1: begin
                        if (q_req.rx_ff) begin o.status = ST_RESP_TO; o.response = BYTE_IDLE; end
                        else begin
                            o.response = q_req.rx_byte;
                            o.status = (phase_reg == PH_STOP_R1 || kind_reg == KIND_CMD)
                                       ? ST_OK : ST_R1_ERR;
                        end
                    end
                    PH_WR_RESP: begin
                        if (q_req.rx_ff) begin o.status = ST_RESP_TO; o.response = BYTE_IDLE; end
                        else begin o.status = ST_REJECTED; o.response = q_req.rx_byte; end
                    end
                    PH_WR_BUSY, PH_STOP_BUSY: if (!q_req.rx_ff) begin
                        o.status = ST_BUSY_TO; o.response = q_req.rx_byte;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; mv_reg <= 1'b0;
            bc_reg <= '0; bl_reg <= '0; pc_reg <= '0;
            cmd_reg <= '0; arg_reg <= '0; kind_reg <= '0;
        end else begin
            if (fire) begin
                res_reg <= o;
                phase_reg <= phase_next;
                bc_reg <= bc_next; bl_reg <= bl_next; pc_reg <= pc_next;
                cmd_reg <= cmd_next; arg_reg <= arg_next; kind_reg <= kind_next;
            end
            if (fire) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_done_desel: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && res_reg.done_res |-> !res_reg.chip_select) else $error("done while selected");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && o.done_res |=> phase_reg == PH_IDLE) else $error("done without idle");
    a_one_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> !(res_reg.read_valid && res_reg.write_taken)) else $error("both strobes");
    a_bc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bc_reg <= BCW'(BLOCK_BYTES)) else $error("byte counter overflow");
`endif
endmodule

FILE: src/sd_spi_transaction_engine.sv
// A 2-entry queue parts front and back; each result is registered at the back end.
// Throughput: one request per clock, unless m_ready holds off the output register.
// The output register holds a result while the next request is taken.
// Reset: synchronous active-low aresetn returns to idle with default poll limits.
// Top level: APB config registers, front end, back end. Depends on sdspi_pkg.
module sd_spi_transaction_engine import sdspi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [2:0]  s_kind,
    input  logic [5:0]  s_cmd_index,
    input  logic [31:0] s_argument,
    input  logic [7:0]  s_block_count,
    input  logic [7:0]  s_rx_byte,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_tx_byte,
    output logic        m_chip_select,
    output logic        m_read_valid,
    output logic [7:0]  m_read_byte,
    output logic        m_write_taken,
    output logic        m_done_res,
    output logic [2:0]  m_status,
    output logic [7:0]  m_response
);
    logic [7:0] resp_limit_reg;
    logic [15:0] busy_limit_reg;
    logic q_valid, q_ready;
    req_t q_req;
    res_t res;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resp_limit_reg <= 8'd22;
            busy_limit_reg <= 16'hFFFE;
        end else if (wr && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_RESP_LIMIT) resp_limit_reg <= pwdata[7:0];
            else busy_limit_reg <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_BUSY_LIMIT) prdata = {16'd0, busy_limit_reg};
            else prdata = {24'd0, resp_limit_reg};
        end
    end

    sdspi_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_op, .s_kind, .s_cmd_index, .s_argument,
        .s_block_count, .s_rx_byte, .s_write_data, .q_valid, .q_ready, .q_req
    );

    sdspi_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_req,
        .resp_limit(resp_limit_reg), .busy_limit(busy_limit_reg),
        .m_valid, .m_ready, .m_res(res)
    );

    assign m_tx_byte = res.tx_byte;
    assign m_chip_select = res.chip_select;
    assign m_read_valid = res.read_valid;
    assign m_read_byte = res.read_byte;
    assign m_write_taken = res.write_taken;
    assign m_done_res = res.done_res;
    assign m_status = res.status;
    assign m_response = res.response;
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for sd_spi_transaction_engine: request driver, byte-exchange predictor, checker.
// Depends on sdspi_pkg and the RTL top level.
module tb;
    import sdspi_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = 1'b0;
    logic [2:0]  s_kind = '0;
    logic [5:0]  s_cmd_index = '0;
    logic [31:0] s_argument = '0;
    logic [7:0]  s_block_count = '0;
    logic [7:0]  s_rx_byte = '0;
    logic [7:0]  s_write_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_tx_byte;
    logic        m_chip_select, m_read_valid, m_write_taken, m_done_res;
    logic [7:0]  m_read_byte, m_response;
    logic [2:0]  m_status;

    localparam logic [2:0] KIND_WR_SINGLE = 3'd3;
    localparam logic [0:0] OP_BYTE = 1'b1;
    localparam int WATCHDOG_LIMIT = 200000;

    sd_spi_transaction_engine dut (.*);

    always #2 aclk = ~aclk;

    // predictor state
    logic [7:0]  resp_limit;
    logic [15:0] busy_limit;
    phase_t      ph;
    int unsigned bcnt;
    logic [7:0]  blk_left;
    int unsigned pcnt;
    logic [5:0]  cur_cmd;
    logic [31:0] cur_arg;
    logic [2:0]  cur_kind;

    res_t exp_bytes[$];
    int   errors = 0;
    int   send_idle_pct = 0, recv_idle_pct = 0;
    bit   hold_recv = 1'b0;
    int   stall_cnt = 0;
    int   n_sent = 0;

    // mirror of the card side; unused, card_reply shapes the rx bytes from ph
    phase_t sent_ph;

    function automatic logic [7:0] frame_of(logic [5:0] c, logic [31:0] a, int unsigned n);
        if (n == 0) return 8'h40 | {2'b00, c};
        if (n <= 4) return a[8*(4-n) +: 8];
        if (c == 6'd0) return 8'h95;
        if (c == 6'd8) return 8'h87;
        return 8'hFF;
    endfunction

    function automatic res_t busy_byte(logic [7:0] tx, logic rv, logic [7:0] rb, logic wt);
        res_t r;
        r = '0;
        r.tx_byte = tx; r.chip_select = 1'b1; r.read_valid = rv;
        r.read_byte = rb; r.write_taken = wt;
        return r;
    endfunction

    function automatic res_t end_txn(logic [2:0] st, logic [7:0] resp);
        res_t r;
        r = '0;
        ph = PH_IDLE;
        r.tx_byte = 8'hFF; r.done_res = 1'b1; r.status = st; r.response = resp;
        return r;
    endfunction

    function automatic res_t frame_step(logic [5:0] c, logic [31:0] a, phase_t nxt);
        if (bcnt < 6) begin
            bcnt++;
            return busy_byte(frame_of(c, a, bcnt - 1), 0, 0, 0);
        end
        ph = nxt;
        pcnt = 1;
        return busy_byte(8'hFF, 0, 0, 0);
    endfunction

    function automatic res_t predict_exchange(logic op, logic [2:0] kind, logic [5:0] ci,
                                              logic [31:0] arg, logic [7:0] cnt,
                                              logic [7:0] rx, logic [7:0] wd);
        res_t r;
        bit rd, multi;
        r = '0;
        if (op == OP_START) begin
            cur_kind = (kind > 3'd4) ? KIND_CMD : kind;
            cur_cmd = ci;
            cur_arg = arg;
            blk_left = (cur_kind == KIND_RD_MULTI || cur_kind == KIND_WR_MULTI) ?
                       ((cnt != 0) ? cnt : 8'd1) : 8'd1;
            pcnt = 0;
            bcnt = 1;
            ph = PH_CMD;
            return busy_byte(frame_of(cur_cmd, cur_arg, 0), 0, 0, 0);
        end
        rd = (cur_kind == KIND_RD_SINGLE || cur_kind == KIND_RD_MULTI);
        multi = (cur_kind == KIND_RD_MULTI || cur_kind == KIND_WR_MULTI);
        case (ph)
            PH_CMD: r = frame_step(cur_cmd, cur_arg, PH_R1);
            PH_STOP: r = frame_step(CMD_STOP_TRANS, 32'd0, PH_STOP_R1);
            PH_R1, PH_STOP_R1: begin
                if (rx == 8'hFF) begin
                    if (pcnt >= resp_limit) r = end_txn(ST_RESP_TO, 8'hFF);
                    else begin pcnt++; r = busy_byte(8'hFF, 0, 0, 0); end
                end else if (ph == PH_STOP_R1 || cur_kind == KIND_CMD) r = end_txn(ST_OK, rx);
                else if (rx != 0) r = end_txn(ST_R1_ERR, rx);
                else if (rd) begin ph = PH_RD_TOKEN; r = busy_byte(8'hFF, 0, 0, 0); end
                else begin ph = PH_WR_PRE; bcnt = 1; r = busy_byte(8'hFF, 0, 0, 0); end
            end
            PH_RD_TOKEN: begin
                if (rx == 8'hFE) begin ph = PH_RD_DATA; bcnt = 0; end
                r = busy_byte(8'hFF, 0, 0, 0);
            end
            PH_RD_DATA: begin
                r = busy_byte(8'hFF, 1, rx, 0);
                bcnt++;
                if (bcnt >= BLOCK_BYTES) begin ph = PH_RD_CRC; bcnt = 0; end
            end
            PH_RD_CRC: begin
                bcnt++;
                if (bcnt < 2) r = busy_byte(8'hFF, 0, 0, 0);
                else begin
                    if (blk_left != 0) blk_left--;
                    if (!multi) r = end_txn(ST_OK, 8'h00);
                    else if (blk_left != 0) begin
                        ph = PH_RD_TOKEN; r = busy_byte(8'hFF, 0, 0, 0);
                    end else begin
                        ph = PH_STOP; bcnt = 1;
                        r = busy_byte(frame_of(CMD_STOP_TRANS, 0, 0), 0, 0, 0);
                    end
                end
            end
            PH_WR_PRE: begin
                if (bcnt < 3) begin bcnt++; r = busy_byte(8'hFF, 0, 0, 0); end
                else begin
                    ph = PH_WR_DATA; bcnt = 0;
                    r = busy_byte(multi ? 8'hFC : 8'hFE, 0, 0, 0);
                end
            end
            PH_WR_DATA: begin
                r = busy_byte(wd, 0, 0, 1);
                bcnt++;
                if (bcnt >= BLOCK_BYTES) begin ph = PH_WR_CRC; bcnt = 0; end
            end
            PH_WR_CRC: begin
                if (bcnt < 2) begin bcnt++; r = busy_byte(8'hFF, 0, 0, 0); end
                else begin ph = PH_WR_RESP; pcnt = 1; r = busy_byte(8'hFF, 0, 0, 0); end
            end
            PH_WR_RESP: begin
                if (rx == 8'hFF) begin
                    if (pcnt >= resp_limit) r = end_txn(ST_RESP_TO, 8'hFF);
                    else begin pcnt++; r = busy_byte(8'hFF, 0, 0, 0); end
                end else if (rx[4:0] != 5'h05) r = end_txn(ST_REJECTED, rx);
                else begin
                    if (blk_left != 0) blk_left--;
                    ph = PH_WR_BUSY; pcnt = 1; r = busy_byte(8'hFF, 0, 0, 0);
                end
            end
            PH_WR_BUSY, PH_STOP_BUSY: begin
                if (rx == 8'hFF) begin
                    if (ph == PH_STOP_BUSY || !multi) r = end_txn(ST_OK, 8'h00);
                    else if (blk_left != 0) begin
                        ph = PH_WR_PRE; bcnt = 0; r = busy_byte(8'hFF, 0, 0, 0);
                    end else begin ph = PH_WR_FD; r = busy_byte(8'hFF, 0, 0, 0); end
                end else if (pcnt >= busy_limit) r = end_txn(ST_BUSY_TO, rx);
                else begin pcnt++; r = busy_byte(8'hFF, 0, 0, 0); end
            end
            PH_WR_FD: begin ph = PH_WR_FD_SENT; r = busy_byte(8'hFD, 0, 0, 0); end
            PH_WR_FD_SENT: begin
                ph = PH_STOP_BUSY; pcnt = 1; r = busy_byte(8'hFF, 0, 0, 0);
            end
            default: begin ph = PH_IDLE; r = '0; r.tx_byte = 8'hFF; end
        endcase
        return r;
    endfunction

    // drive one request and record its expected result; valid stays up for the next one
    task automatic send_request(logic op, logic [2:0] kind, logic [5:0] ci, logic [31:0] arg,
                                logic [7:0] cnt, logic [7:0] rx, logic [7:0] wd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1; s_op <= op; s_kind <= kind; s_cmd_index <= ci;
        s_argument <= arg; s_block_count <= cnt; s_rx_byte <= rx; s_write_data <= wd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        exp_bytes.push_back(predict_exchange(op, kind, ci, arg, cnt, rx, wd));
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic start_txn(logic [2:0] kind, logic [5:0] ci, logic [31:0] arg,
                             logic [7:0] cnt);
        send_request(OP_START, kind, ci, arg, cnt, 8'($urandom), 8'($urandom));
    endtask

    task automatic xfer(logic [7:0] rx);
        send_request(OP_BYTE, 3'($urandom), 6'($urandom), $urandom, 8'($urandom), rx,
                     8'($urandom));
    endtask

    // card-like reply for the current phase; noise keeps the odd branches alive
    function automatic logic [7:0] card_reply();
        int n;
        n = $urandom_range(99);
        if (n < 3) return 8'($urandom);
        case (ph)
            PH_R1, PH_STOP_R1: return (n < 30) ? 8'hFF : (n < 90 ? 8'h00 : 8'($urandom));
            PH_RD_TOKEN: return (n < 40) ? 8'hFE : ((n < 50) ? 8'($urandom) : 8'hFF);
            PH_WR_RESP: return (n < 30) ? 8'hFF :
                               (n < 90 ? {3'($urandom_range(7)), 5'h05} : 8'($urandom));
            PH_WR_BUSY, PH_STOP_BUSY: return (n < 40) ? 8'hFF : 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic run_txn(logic [2:0] kind, logic [7:0] cnt, int max_bytes);
        int k;
        start_txn(kind, 6'($urandom), $urandom, cnt);
        k = 0;
        while (ph != PH_IDLE && k < max_bytes) begin
            xfer(card_reply());
            k++;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (exp_bytes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic reg_write(logic [0:0] idx, logic [31:0] val);
        s_valid <= 1'b0;
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_RESP_LIMIT) resp_limit = val[7:0];
        else busy_limit = val[15:0];
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic test_directed();
        int i;
        // command frames with the CMD0 and CMD8 CRC cases
        start_txn(KIND_CMD, 6'd0, 32'h0000_0000, 8'd0);
        repeat (6) xfer(8'hFF);
        xfer(8'h01);
        start_txn(KIND_CMD, 6'd8, 32'hFFFF_FFFF, 8'd255);
        repeat (6) xfer(8'h00);
        xfer(8'h00);
        // kind above four, response timeout at limit one
        start_txn(3'd7, 6'd63, 32'hA5A5_5A5A, 8'd1);
        for (i = 0; i < 8; i++) xfer(8'hFF);
        // byte while idle, read response timeout, byte while idle, abort by new start
        xfer(8'h00);
        start_txn(KIND_RD_SINGLE, 6'd17, 32'h1234_5678, 8'd0);
        repeat (7) xfer(8'hFF);
        xfer(8'h04);
        start_txn(KIND_WR_SINGLE, 6'd24, 32'h0, 8'd0);
        xfer(8'hFF);
        start_txn(KIND_WR_MULTI, 6'd25, 32'h1, 8'd0);
    endtask

    // random transactions until about n_items requests have gone out
    task automatic test_random(int n_items);
        int target, room;
        target = n_sent + n_items;
        while (n_sent < target) begin
            room = target - n_sent - 1;
            if ($urandom_range(99) < 15)
                run_txn(3'($urandom_range(7)), 8'($urandom_range(2)), (room < 30) ? room : 30);
            else
                run_txn(3'($urandom_range(4)), 8'($urandom_range(2)), room);
        end
    endtask

    task automatic test_backpressure();
        int i;
        hold_recv = 1'b1;
        fork
            begin repeat (300) @(posedge aclk); hold_recv = 1'b0; end
            begin
                start_txn(KIND_CMD, 6'd55, 32'h0, 8'd1);
                for (i = 0; i < 20; i++) xfer(8'hFF);
            end
        join
        wait_drained();
    endtask

    // checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (exp_bytes.size() == 0) begin
                $display("%0t: unexpected result tx=%h", $time, m_tx_byte);
                errors++;
            end else begin
                res_t e, a;
                e = exp_bytes.pop_front();
                a = '{m_tx_byte, m_chip_select, m_read_valid, m_read_byte, m_write_taken,
                      m_done_res, m_status, m_response};
                if (a !== e) begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, a);
                    errors++;
                end
            end
        end
    end

    always @(negedge aclk)
        m_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);

    // watchdog on cycles with no acceptance
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) stall_cnt <= 0;
        else if (s_valid || exp_bytes.size() != 0) begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        resp_limit = 8'd22;
        busy_limit = 16'd65534;
        ph = PH_IDLE; bcnt = 0; blk_left = 0; pcnt = 0;
        cur_cmd = 0; cur_arg = 0; cur_kind = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        reg_write(REG_RESP_LIMIT, 32'd1);
        reg_write(REG_BUSY_LIMIT, 32'd1);
        send_idle_pct = 34; recv_idle_pct = 50;
        test_directed();
        wait_drained();
        reg_write(REG_RESP_LIMIT, 32'd255);
        reg_write(REG_BUSY_LIMIT, 32'd65535);
        test_backpressure();
        reg_write(REG_RESP_LIMIT, 32'd3);
        reg_write(REG_BUSY_LIMIT, 32'd5);
        test_random(550);
        wait_drained();
        send_idle_pct = 50; recv_idle_pct = 34;
        reg_write(REG_RESP_LIMIT, 32'd4);
        reg_write(REG_BUSY_LIMIT, 32'd3);
        test_random(550);
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
        reg_write(REG_RESP_LIMIT, 32'd2);
        test_random(800);
        wait_drained();
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
